@@ design/char_lcd_nibble_write_sequencer_defines.svh @@
// Assertion macros used by the lcdns_out_skid module.
`ifndef CHAR_LCD_NIBBLE_WRITE_SEQUENCER_DEFINES_SVH
`define CHAR_LCD_NIBBLE_WRITE_SEQUENCER_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define LCDNS_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("lcdns assertion failed");

// Next-cycle implication, checked outside reset.
`define LCDNS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("lcdns assertion failed");

`endif

@@ design/lcdns_pkg.sv @@
// ----------------------------------------------------------------------------
// lcdns_pkg
// Types, codes and helpers for the character LCD nibble write sequencer.
// ----------------------------------------------------------------------------
`default_nettype none

package lcdns_pkg;

    localparam int unsigned CfgAddrWidth = 5;
    localparam logic [2:0]  INIT_COUNT   = 3'd6;
    localparam logic [7:0]  INIT_CMD_A   = 8'h33;
    localparam logic [7:0]  INIT_CMD_B   = 8'h32;
    localparam logic [7:0]  CLEAR_CMD    = 8'h01;

    typedef enum logic [2:0] {
        REG_NIBBLE_TICKS  = 3'd0,
        REG_SETTLE_TICKS  = 3'd1,
        REG_MAX_COLUMN    = 3'd2,
        REG_FUNCTION_SET  = 3'd3,
        REG_DISPLAY_ON    = 3'd4,
        REG_ENTRY_MODE    = 3'd5,
        REG_FIRST_ROW     = 3'd6,
        REG_SECOND_ROW    = 3'd7
    } t_reg_index;

    typedef enum logic [2:0] {
        ACT_TICK     = 3'd0,
        ACT_COMMAND  = 3'd1,
        ACT_DATA     = 3'd2,
        ACT_POSITION = 3'd3,
        ACT_INIT     = 3'd4
    } t_action;

    typedef enum logic [2:0] {
        ST_NONE       = 3'd0,
        ST_ACCEPTED   = 3'd1,
        ST_POS_ERROR  = 3'd2,
        ST_BUSY       = 3'd3,
        ST_WRITE_DONE = 3'd4,
        ST_INIT_DONE  = 3'd5
    } t_status;

    typedef enum logic [1:0] {
        PH_IDLE   = 2'd0,
        PH_HIGH   = 2'd1,
        PH_LOW    = 2'd2,
        PH_SETTLE = 2'd3
    } t_phase;

    typedef struct packed {
        logic [2:0] action;
        logic [7:0] byte_value;
        logic [1:0] row_select;
        logic [7:0] column;
    } t_in_item;

    typedef struct packed {
        logic [3:0] lcd_nibble;
        logic       reg_select;
        logic       read_write;
        logic       enable;
        logic       busy_res;
        logic [2:0] status;
    } t_out_item;

    typedef struct packed {
        logic [7:0] nibble_ticks;
        logic [7:0] settle_ticks;
        logic [5:0] max_column;
        logic [7:0] function_set_cmd;
        logic [7:0] display_on_cmd;
        logic [7:0] entry_mode_cmd;
        logic [7:0] first_row_base;
        logic [7:0] second_row_base;
    } t_cfg;

    function automatic logic [7:0] init_cmd(input logic [2:0] step, input t_cfg cfg);
        logic [7:0] cmd;
        unique case (step)
            3'd0:    cmd = INIT_CMD_A;
            3'd1:    cmd = INIT_CMD_B;
            3'd2:    cmd = cfg.function_set_cmd;
            3'd3:    cmd = cfg.display_on_cmd;
            3'd4:    cmd = cfg.entry_mode_cmd;
            default: cmd = CLEAR_CMD;
        endcase
        return cmd;
    endfunction

endpackage

`default_nettype wire

@@ design/lcdns_cfg_regs.sv @@
// ----------------------------------------------------------------------------
// lcdns_cfg_regs
// APB-style register file holding timing, the column limit, init commands and row bases.
// ----------------------------------------------------------------------------
`default_nettype none

module lcdns_cfg_regs (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              psel,
    input  wire logic                              penable,
    input  wire logic                              pwrite,
    input  wire logic [lcdns_pkg::CfgAddrWidth-1:0] paddr,
    input  wire logic [31:0]                       pwdata,
    output logic [31:0]                            prdata,
    output logic                                   pready,
    output lcdns_pkg::t_cfg                        o_cfg
);
    import lcdns_pkg::*;

    t_cfg       r_cfg;
    t_reg_index w_index;
    logic       w_write;

    assign w_index = t_reg_index'(paddr[CfgAddrWidth-1:2]);
    assign w_write = psel && penable && pwrite;
    assign pready  = 1'b1;
    assign o_cfg   = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.nibble_ticks     <= 8'd3;
            r_cfg.settle_ticks     <= 8'd1;
            r_cfg.max_column       <= 6'd15;
            r_cfg.function_set_cmd <= 8'h28;
            r_cfg.display_on_cmd   <= 8'h0C;
            r_cfg.entry_mode_cmd   <= 8'h06;
            r_cfg.first_row_base   <= 8'h80;
            r_cfg.second_row_base  <= 8'hC0;
        end else if (w_write) begin
            unique case (w_index)
                REG_NIBBLE_TICKS: r_cfg.nibble_ticks     <= pwdata[7:0];
                REG_SETTLE_TICKS: r_cfg.settle_ticks     <= pwdata[7:0];
                REG_MAX_COLUMN:   r_cfg.max_column       <= pwdata[5:0];
                REG_FUNCTION_SET: r_cfg.function_set_cmd <= pwdata[7:0];
                REG_DISPLAY_ON:   r_cfg.display_on_cmd   <= pwdata[7:0];
                REG_ENTRY_MODE:   r_cfg.entry_mode_cmd   <= pwdata[7:0];
                REG_FIRST_ROW:    r_cfg.first_row_base   <= pwdata[7:0];
                REG_SECOND_ROW:   r_cfg.second_row_base  <= pwdata[7:0];
                default:          ;
            endcase
        end
    end

    always_comb begin
        unique case (w_index)
            REG_NIBBLE_TICKS: prdata = {24'd0, r_cfg.nibble_ticks};
            REG_SETTLE_TICKS: prdata = {24'd0, r_cfg.settle_ticks};
            REG_MAX_COLUMN:   prdata = {26'd0, r_cfg.max_column};
            REG_FUNCTION_SET: prdata = {24'd0, r_cfg.function_set_cmd};
            REG_DISPLAY_ON:   prdata = {24'd0, r_cfg.display_on_cmd};
            REG_ENTRY_MODE:   prdata = {24'd0, r_cfg.entry_mode_cmd};
            REG_FIRST_ROW:    prdata = {24'd0, r_cfg.first_row_base};
            REG_SECOND_ROW:   prdata = {24'd0, r_cfg.second_row_base};
            default:          prdata = 32'd0;
        endcase
    end

endmodule

`default_nettype wire

@@ design/lcdns_core.sv @@
// ----------------------------------------------------------------------------
// lcdns_core
// Write phase machine, tick counter and init step tracking; forms one result
// word per accepted input word.
// ----------------------------------------------------------------------------
`default_nettype none

module lcdns_core (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire lcdns_pkg::t_cfg      i_cfg,
    input  wire logic                 i_fire,
    input  wire lcdns_pkg::t_in_item  i_item,
    output lcdns_pkg::t_out_item      o_result
);
    import lcdns_pkg::*;

    t_phase     r_phase, n_phase;
    logic [7:0] r_tick, n_tick;
    logic [7:0] r_byte, n_byte;
    logic       r_rs, n_rs;
    logic [2:0] r_step, n_step;
    logic       r_active, n_active;
    t_status    n_status;

    logic       w_busy;
    logic [8:0] w_cnt_inc;
    logic       w_nib_done;
    logic       w_set_done;
    logic [2:0] w_step_inc;
    logic       w_pos_bad;
    logic [7:0] w_pos_addr;

    // A limit of zero ends the phase on its first tick, as a limit of one does.
    assign w_busy     = (r_phase != PH_IDLE) || r_active;
    assign w_cnt_inc  = {1'b0, r_tick} + 9'd1;
    assign w_nib_done = w_cnt_inc >= {1'b0, i_cfg.nibble_ticks};
    assign w_set_done = w_cnt_inc >= {1'b0, i_cfg.settle_ticks};
    assign w_step_inc = r_step + 3'd1;
    assign w_pos_bad  = (i_item.column > {2'b00, i_cfg.max_column}) || i_item.row_select[1];
    assign w_pos_addr = i_item.column |
                        (i_item.row_select[0] ? i_cfg.second_row_base : i_cfg.first_row_base);

    // Next state.
    always_comb begin
        n_phase  = r_phase;
        n_tick   = r_tick;
        n_byte   = r_byte;
        n_rs     = r_rs;
        n_step   = r_step;
        n_active = r_active;
        n_status = ST_NONE;
        unique case (i_item.action)
            ACT_TICK: begin
                unique case (r_phase)
                    PH_HIGH: begin
                        if (w_nib_done) begin
                            n_tick  = 8'd0;
                            n_phase = PH_LOW;
                        end else begin
                            n_tick = w_cnt_inc[7:0];
                        end
                    end
                    PH_LOW: begin
                        if (w_nib_done) begin
                            n_tick  = 8'd0;
                            n_phase = PH_SETTLE;
                        end else begin
                            n_tick = w_cnt_inc[7:0];
                        end
                    end
                    PH_SETTLE: begin
                        if (!w_set_done) begin
                            n_tick = w_cnt_inc[7:0];
                        end else begin
                            n_tick  = 8'd0;
                            n_phase = PH_IDLE;
                            if (!r_active) begin
                                n_status = ST_WRITE_DONE;
                            end else if (w_step_inc >= INIT_COUNT) begin
                                n_step   = 3'd0;
                                n_active = 1'b0;
                                n_status = ST_INIT_DONE;
                            end else begin
                                // The next init command goes out without a gap.
                                n_step  = w_step_inc;
                                n_byte  = init_cmd(w_step_inc, i_cfg);
                                n_rs    = 1'b0;
                                n_phase = PH_HIGH;
                            end
                        end
                    end
                    default: ;
                endcase
            end
            ACT_COMMAND, ACT_DATA: begin
                if (w_busy) begin
                    n_status = ST_BUSY;
                end else begin
                    n_byte   = i_item.byte_value;
                    n_rs     = (i_item.action == ACT_DATA);
                    n_phase  = PH_HIGH;
                    n_tick   = 8'd0;
                    n_status = ST_ACCEPTED;
                end
            end
            ACT_POSITION: begin
                if (w_pos_bad) begin
                    n_status = ST_POS_ERROR;
                end else if (w_busy) begin
                    n_status = ST_BUSY;
                end else begin
                    n_byte   = w_pos_addr;
                    n_rs     = 1'b0;
                    n_phase  = PH_HIGH;
                    n_tick   = 8'd0;
                    n_status = ST_ACCEPTED;
                end
            end
            ACT_INIT: begin
                if (w_busy) begin
                    n_status = ST_BUSY;
                end else begin
                    n_active = 1'b1;
                    n_step   = 3'd0;
                    n_byte   = INIT_CMD_A;
                    n_rs     = 1'b0;
                    n_phase  = PH_HIGH;
                    n_tick   = 8'd0;
                    n_status = ST_ACCEPTED;
                end
            end
            default: ;
        endcase
    end

    // Result word, taken from the state after this word's update.
    always_comb begin
        o_result.lcd_nibble = (n_phase == PH_HIGH) ? n_byte[7:4] : n_byte[3:0];
        o_result.reg_select = n_rs;
        o_result.read_write = 1'b0;
        o_result.enable     = (n_phase == PH_HIGH) || (n_phase == PH_LOW);
        o_result.busy_res   = (n_phase != PH_IDLE) || n_active;
        o_result.status     = n_status;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= PH_IDLE;
            r_tick   <= 8'd0;
            r_byte   <= 8'd0;
            r_rs     <= 1'b0;
            r_step   <= 3'd0;
            r_active <= 1'b0;
        end else if (i_fire) begin
            r_phase  <= n_phase;
            r_tick   <= n_tick;
            r_byte   <= n_byte;
            r_rs     <= n_rs;
            r_step   <= n_step;
            r_active <= n_active;
        end
    end

endmodule

`default_nettype wire

@@ design/lcdns_out_skid.sv @@
// ----------------------------------------------------------------------------
// lcdns_out_skid
// Two-entry result buffer: an output register plus a skid register, so the
// input side keeps moving while one result waits downstream.
// ----------------------------------------------------------------------------
`default_nettype none

`include "char_lcd_nibble_write_sequencer_defines.svh"

module lcdns_out_skid (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_push,
    input  wire lcdns_pkg::t_out_item i_data,
    output logic                      o_full,
    output logic                      o_valid,
    input  wire logic                 i_stall,
    output lcdns_pkg::t_out_item      o_data
);
    import lcdns_pkg::*;

    t_out_item r_main;
    t_out_item r_skid;
    logic      r_main_valid;
    logic      r_skid_valid;
    logic      w_pop;

    assign w_pop   = r_main_valid && !i_stall;
    assign o_valid = r_main_valid;
    assign o_data  = r_main;
    assign o_full  = r_skid_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_main_valid <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (w_pop) begin
            if (r_skid_valid) begin
                r_main_valid <= 1'b1;
                r_skid_valid <= 1'b0;
            end else begin
                r_main_valid <= i_push;
            end
        end else if (i_push) begin
            if (r_main_valid) begin
                r_skid_valid <= 1'b1;
            end else begin
                r_main_valid <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_pop) begin
            r_main <= r_skid_valid ? r_skid : i_data;
        end else if (i_push) begin
            if (r_main_valid) begin
                r_skid <= i_data;
            end else begin
                r_main <= i_data;
            end
        end
    end

    `LCDNS_ASSERT_NOW(a_skid_needs_main, i_clk, i_rst_n, r_skid_valid, r_main_valid)
    `LCDNS_ASSERT_NOW(a_no_push_when_full, i_clk, i_rst_n, i_push, !r_skid_valid)
    `LCDNS_ASSERT_NEXT(a_held_valid_stays, i_clk, i_rst_n, r_main_valid && i_stall, r_main_valid)
    `LCDNS_ASSERT_NEXT(a_held_word_stays, i_clk, i_rst_n, r_main_valid && i_stall, $stable(r_main))

endmodule

`default_nettype wire

@@ design/char_lcd_nibble_write_sequencer.sv @@
// ----------------------------------------------------------------------------
// char_lcd_nibble_write_sequencer
// Character LCD controller for a 4-bit bus: nibble strobing, settle timing,
// init run and cursor positioning, one result word per input word.
// ----------------------------------------------------------------------------
//  channel  | direction | handshake               | word
//  in       | input     | i_in_valid / o_in_stall | t_in_item (action, byte, row, col)
//  out      | output    | o_out_valid / i_out_stall | t_out_item (lines, busy, status)
//  cfg      | input     | APB psel/penable/pwrite | eight registers, 6 to 8 bits
//
// Every input word is processed in the cycle it is accepted; its result is
// registered into the output register, or into the skid register while the
// output register is held. One word per cycle is sustained, a limit set by
// the two-entry output buffer: o_in_stall rises only when both entries hold
// results not yet taken downstream. Synchronous active-low reset clears the
// phase machine and both buffer entries; configuration returns to its defaults.
// ----------------------------------------------------------------------------
`default_nettype none

module char_lcd_nibble_write_sequencer (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    input  wire logic                               i_in_valid,
    output logic                                    o_in_stall,
    input  wire lcdns_pkg::t_in_item                i_in,
    output logic                                    o_out_valid,
    input  wire logic                               i_out_stall,
    output lcdns_pkg::t_out_item                    o_out,
    input  wire logic                               psel,
    input  wire logic                               penable,
    input  wire logic                               pwrite,
    input  wire logic [lcdns_pkg::CfgAddrWidth-1:0] paddr,
    input  wire logic [31:0]                        pwdata,
    output logic [31:0]                             prdata,
    output logic                                    pready
);
    import lcdns_pkg::*;

    t_cfg      w_cfg;
    t_out_item w_result;
    logic      w_full;
    logic      w_fire;

    assign o_in_stall = w_full;
    assign w_fire     = i_in_valid && !w_full;

    lcdns_cfg_regs u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (w_cfg)
    );

    lcdns_core u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cfg    (w_cfg),
        .i_fire   (w_fire),
        .i_item   (i_in),
        .o_result (w_result)
    );

    lcdns_out_skid u_out (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_fire),
        .i_data  (w_result),
        .o_full  (w_full),
        .o_valid (o_out_valid),
        .i_stall (i_out_stall),
        .o_data  (o_out)
    );

endmodule

`default_nettype wire
